### hw/rtl/dnsa_pkg.sv
// Shared types and constants for the DNS answer A-record scanner.
package dnsa_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_QNAME  = 3'd1,
    PH_QTAIL  = 3'd2,
    PH_ANAME  = 3'd3,
    PH_AFIXED = 3'd4,
    PH_RDATA  = 3'd5,
    PH_DONE   = 3'd6
  } phase_t;

  // Position inside a name
  typedef enum logic [1:0] {
    NAME_FRESH = 2'd0,
    NAME_PTR   = 2'd1,
    NAME_IN    = 2'd2
  } name_pos_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_ID_MISS   = 2'd1,
    ST_NO_A      = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_t;

  localparam int unsigned LabelLenW   = 6;
  localparam logic [3:0]  HeaderLast  = 4'd11;
  localparam logic [3:0]  QtailLast   = 4'd3;
  localparam logic [3:0]  FixedLast   = 4'd9;
  localparam logic [15:0] TypeA       = 16'h0001;
  localparam logic [15:0] ClassIn     = 16'h0001;
  localparam logic [15:0] RdlenIpv4   = 16'h0004;

  // One classified packet byte
  typedef struct packed {
    logic [7:0]           data_byte;
    logic                 last_byte;
    logic [15:0]          expected_id;
    logic                 is_ptr;
    logic [LabelLenW-1:0] label_len;
  } item_t;

endpackage

### hw/rtl/dnsa_front.sv
// Front end: accepts packet bytes and classifies them as name label codes.
module dnsa_front (
  input  logic              item_valid,
  output logic              item_ready,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic [15:0]       expected_id,
  output logic              push_valid,
  input  logic              push_ready,
  output dnsa_pkg::item_t   push_item
);
  import dnsa_pkg::*;

  // Pass the handshake straight into the queue
  assign push_valid = item_valid;
  assign item_ready = push_ready;

  // Tag pointer prefix and label length for the name walker
  always_comb begin
    push_item.data_byte   = data_byte;
    push_item.last_byte   = last_byte;
    push_item.expected_id = expected_id;
    push_item.is_ptr      = (data_byte[7:6] == 2'b11);
    push_item.label_len   = data_byte[LabelLenW-1:0];
  end

endmodule

### hw/rtl/dnsa_queue.sv
// Short queue of classified bytes between front end and parser.
module dnsa_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  dnsa_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output dnsa_pkg::item_t pop_item
);
  import dnsa_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t           slots [Depth];
  logic [PtrW-1:0] wptr;
  logic [PtrW-1:0] rptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CntW'(Depth));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store incoming item
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PtrW'(Depth - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PtrW'(Depth - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/dnsa_back.sv
// Back end: walks header, question and answers, and holds the result.
module dnsa_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  dnsa_pkg::item_t        pop_item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output dnsa_pkg::status_t      status,
  output logic [31:0]            ttl,
  output logic [31:0]            ipv4_address
);
  import dnsa_pkg::*;

  phase_t               phase, phase_next;
  logic [3:0]           field_counter, field_counter_next;
  logic [LabelLenW-1:0] label_left, label_left_next;
  logic [15:0]          rdata_left, rdata_left_next;
  logic [15:0]          rec_type, rec_type_next;
  logic [15:0]          rec_class, rec_class_next;
  logic [31:0]          rec_ttl, rec_ttl_next;
  logic [15:0]          rec_len, rec_len_next;
  logic [31:0]          addr, addr_next;
  logic [7:0]           id_low, id_low_next;
  logic                 id_ok, id_ok_next;
  logic                 found, found_next;
  logic                 name_end;
  logic                 step;
  logic                 emit;
  status_t              status_next;
  logic [7:0]           b;

  assign b         = pop_item.data_byte;
  assign pop_ready = !pop_item.last_byte || !result_valid || result_ready;
  assign step      = pop_valid && pop_ready;
  assign emit      = step && pop_item.last_byte;

  // Walk one name byte: label skip, pointer, or terminator
  always_comb begin
    name_end           = 1'b0;
    label_left_next    = label_left;
    field_counter_next = field_counter;
    if (field_counter == 4'(NAME_PTR)) begin
      name_end = 1'b1;
    end else if (label_left != '0) begin
      label_left_next    = label_left - 1'b1;
      field_counter_next = 4'(NAME_IN);
    end else if (pop_item.is_ptr) begin
      field_counter_next = 4'(NAME_PTR);
    end else if (pop_item.label_len == '0) begin
      name_end = 1'b1;
    end else begin
      label_left_next    = pop_item.label_len;
      field_counter_next = 4'(NAME_IN);
    end
  end

  // Next parser state for the byte at the queue head
  logic [3:0]           fc_walk;
  logic [LabelLenW-1:0] ll_walk;
  assign fc_walk = field_counter_next;
  assign ll_walk = label_left_next;

  logic [3:0]           fc_n;
  logic [LabelLenW-1:0] ll_n;

  always_comb begin
    phase_next      = phase;
    fc_n            = field_counter;
    ll_n            = label_left;
    rdata_left_next = rdata_left;
    rec_type_next   = rec_type;
    rec_class_next  = rec_class;
    rec_ttl_next    = rec_ttl;
    rec_len_next    = rec_len;
    addr_next       = addr;
    id_low_next     = id_low;
    id_ok_next      = id_ok;
    found_next      = found;
    case (phase)
      PH_HEADER: begin
        if (field_counter == 4'd0) begin
          id_low_next = pop_item.expected_id[7:0];
          id_ok_next  = (b == pop_item.expected_id[15:8]);
        end else if (field_counter == 4'd1) begin
          id_ok_next = id_ok && (b == id_low);
        end
        if (field_counter >= HeaderLast) begin
          phase_next = PH_QNAME;
          fc_n       = 4'(NAME_FRESH);
          ll_n       = '0;
        end else begin
          fc_n = field_counter + 1'b1;
        end
      end
      PH_QNAME: begin
        fc_n = fc_walk;
        ll_n = ll_walk;
        if (name_end) begin
          phase_next = PH_QTAIL;
          fc_n       = '0;
        end
      end
      PH_QTAIL: begin
        if (field_counter >= QtailLast) begin
          phase_next = PH_ANAME;
          fc_n       = 4'(NAME_FRESH);
          ll_n       = '0;
        end else begin
          fc_n = field_counter + 1'b1;
        end
      end
      PH_ANAME: begin
        fc_n = fc_walk;
        ll_n = ll_walk;
        if (name_end) begin
          phase_next = PH_AFIXED;
          fc_n       = '0;
        end
      end
      PH_AFIXED: begin
        if (field_counter < 4'd2) begin
          rec_type_next = {rec_type[7:0], b};
        end else if (field_counter < 4'd4) begin
          rec_class_next = {rec_class[7:0], b};
        end else if (field_counter < 4'd8) begin
          rec_ttl_next = {rec_ttl[23:0], b};
        end else begin
          rec_len_next = {rec_len[7:0], b};
        end
        if (field_counter >= FixedLast) begin
          if (rec_len_next == '0) begin
            phase_next = PH_ANAME;
            fc_n       = 4'(NAME_FRESH);
            ll_n       = '0;
          end else begin
            rdata_left_next = rec_len_next;
            addr_next       = '0;
            phase_next      = PH_RDATA;
            fc_n            = '0;
          end
        end else begin
          fc_n = field_counter + 1'b1;
        end
      end
      PH_RDATA: begin
        addr_next       = {addr[23:0], b};
        rdata_left_next = rdata_left - 1'b1;
        if (rdata_left_next == '0) begin
          if (rec_type == TypeA && rec_class == ClassIn && rec_len == RdlenIpv4) begin
            found_next = 1'b1;
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_ANAME;
            fc_n       = 4'(NAME_FRESH);
            ll_n       = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Classify how the packet ended
  always_comb begin
    priority if (phase_next == PH_HEADER) begin
      status_next = ST_TRUNCATED;
    end else if (!id_ok_next) begin
      status_next = ST_ID_MISS;
    end else if (found_next) begin
      status_next = ST_FOUND;
    end else if (phase_next == PH_ANAME && fc_n == 4'(NAME_FRESH) && ll_n == '0) begin
      status_next = ST_NO_A;
    end else begin
      status_next = ST_TRUNCATED;
    end
  end

  // Advance parser state; return to start of packet after the last byte
  always_ff @(posedge clk) begin
    if (rst || emit) begin
      phase         <= PH_HEADER;
      field_counter <= '0;
      label_left    <= '0;
      rdata_left    <= '0;
      rec_type      <= '0;
      rec_class     <= '0;
      rec_ttl       <= '0;
      rec_len       <= '0;
      addr          <= '0;
      id_low        <= '0;
      id_ok         <= 1'b0;
      found         <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      field_counter <= fc_n;
      label_left    <= ll_n;
      rdata_left    <= rdata_left_next;
      rec_type      <= rec_type_next;
      rec_class     <= rec_class_next;
      rec_ttl       <= rec_ttl_next;
      rec_len       <= rec_len_next;
      addr          <= addr_next;
      id_low        <= id_low_next;
      id_ok         <= id_ok_next;
      found         <= found_next;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status       <= status_next;
      ttl          <= (status_next == ST_FOUND) ? rec_ttl_next : '0;
      ipv4_address <= (status_next == ST_FOUND) ? addr_next : '0;
    end
  end

endmodule

### hw/rtl/dns_answer_a_record_scanner.sv
// Top level of the DNS answer A-record scanner.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-----------------------------------
//   item     | item_valid / item_ready     | data_byte, last_byte, expected_id
//   result   | result_valid / result_ready | status, ttl, ipv4_address
//
// One packet byte is taken per cycle; the parser consumes one byte per cycle
// from a four-entry queue, so a sustained stream runs at one byte per cycle.
// With the queue empty, the last byte passes a queue slot, then the result register, before result_valid rises.
// Synchronous active-high reset clears the queue, the parser and the result valid flag.
// A stalled result blocks only the next packet's last byte; bytes behind it
// fill the queue, and then the input stalls.
module dns_answer_a_record_scanner #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  input  logic [15:0]          expected_id,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [1:0]           status,
  output logic [31:0]          ttl,
  output logic [31:0]          ipv4_address
);
  import dnsa_pkg::*;

  logic    push_valid;
  logic    push_ready;
  item_t   push_item;
  logic    pop_valid;
  logic    pop_ready;
  item_t   pop_item;
  status_t status_code;

  dnsa_front u_front (
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .expected_id (expected_id),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_item   (push_item)
  );

  dnsa_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  dnsa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_item     (pop_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status_code),
    .ttl          (ttl),
    .ipv4_address (ipv4_address)
  );

  assign status = status_code;

endmodule
